### src/tpsd_pkg.sv
`default_nettype none

package tpsd_pkg;

    // scaled separation magnitude width, its square and its root
    localparam int DM_W = 32;
    localparam int SQ_W = 64;
    localparam int RT_W = 32;

    // clamp width of the axial velocity magnitude
    localparam int VA_W = 33;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STIFFNESS   = 2'd0,
        REG_DAMPING     = 2'd1,
        REG_FREE_LENGTH = 2'd2
    } cfg_reg_t;

endpackage

`default_nettype wire

### src/tpsd_in_if.sv
`default_nettype none

interface tpsd_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] first_pos_x;
    logic signed [DATA_WIDTH-1:0] first_pos_y;
    logic signed [DATA_WIDTH-1:0] first_pos_z;
    logic signed [DATA_WIDTH-1:0] second_pos_x;
    logic signed [DATA_WIDTH-1:0] second_pos_y;
    logic signed [DATA_WIDTH-1:0] second_pos_z;
    logic signed [DATA_WIDTH-1:0] first_vel_x;
    logic signed [DATA_WIDTH-1:0] first_vel_y;
    logic signed [DATA_WIDTH-1:0] first_vel_z;
    logic signed [DATA_WIDTH-1:0] second_vel_x;
    logic signed [DATA_WIDTH-1:0] second_vel_y;
    logic signed [DATA_WIDTH-1:0] second_vel_z;

    modport source (
        output valid,
        output first_pos_x, first_pos_y, first_pos_z,
        output second_pos_x, second_pos_y, second_pos_z,
        output first_vel_x, first_vel_y, first_vel_z,
        output second_vel_x, second_vel_y, second_vel_z,
        input  ready
    );

    modport sink (
        input  valid,
        input  first_pos_x, first_pos_y, first_pos_z,
        input  second_pos_x, second_pos_y, second_pos_z,
        input  first_vel_x, first_vel_y, first_vel_z,
        input  second_vel_x, second_vel_y, second_vel_z,
        output ready
    );
endinterface

`default_nettype wire

### src/tpsd_out_if.sv
`default_nettype none

interface tpsd_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] force_x;
    logic signed [DATA_WIDTH-1:0] force_y;
    logic signed [DATA_WIDTH-1:0] force_z;
    logic                         zero_length;

    modport source (
        output valid,
        output force_x, force_y, force_z, zero_length,
        input  ready
    );

    modport sink (
        input  valid,
        input  force_x, force_y, force_z, zero_length,
        output ready
    );
endinterface

`default_nettype wire

### src/tpsd_div_pipe.sv
`default_nettype none

// restoring divider, one quotient bit per stage; quotient must fit QUO_W bits
module tpsd_div_pipe #(
    parameter int DEN_W = 32,
    parameter int QUO_W = 33
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [DEN_W+QUO_W-1:0] num,
    input  logic [DEN_W-1:0]       den,
    output logic [QUO_W-1:0]       quo
);

    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] low_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        logic [DEN_W-1:0] rem_prev;
        logic [QUO_W-1:0] low_prev;
        logic [QUO_W-1:0] quo_prev;
        logic [DEN_W-1:0] den_prev;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             take;
        logic [DEN_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        if (k == 0)
        begin : g_first
            assign rem_prev = num[DEN_W+QUO_W-1:QUO_W];
            assign low_prev = num[QUO_W-1:0];
            assign quo_prev = '0;
            assign den_prev = den;
        end
        else
        begin : g_rest
            assign rem_prev = rem_reg[k-1];
            assign low_prev = low_reg[k-1];
            assign quo_prev = quo_reg[k-1];
            assign den_prev = den_reg[k-1];
        end

        assign trial    = {rem_prev, low_prev[QUO_W-1]};
        assign diff     = trial - {1'b0, den_prev};
        assign take     = (trial >= {1'b0, den_prev});
        assign rem_next = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        assign quo_next = {quo_prev[QUO_W-2:0], take};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                low_reg[k] <= low_prev << 1;
                quo_reg[k] <= quo_next;
                den_reg[k] <= den_prev;
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

`default_nettype wire

### src/two_point_spring_damper_force_top.sv
`default_nettype none

// channel   | dir | contents
// ----------+-----+-----------------------------------------------------------
// points    | in  | positions and velocities of both attachment points
// result    | out | force on the first point and the coincident-points flag
// cfg_*     | in  | register write: stiffness, damping, free length
//
// one transfer per clock in and out unless the receiver holds a result back;
// the depth is set by the 32-stage square root and the two bit-per-stage dividers
// (axial velocity and force direction), each as long as its quotient is wide
// reset clears the stage valid bits and the three registers to zero
// the pipe moves whenever the result register is free or the stage in front
// of it is empty, so bubbles close up while a result waits to be taken

module two_point_spring_damper_force_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tpsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_WIDTH-2:0]              cfg_data,
    tpsd_in_if.sink                            points,
    tpsd_out_if.source                         result
);

    localparam int W      = DATA_WIDTH;
    localparam int DW     = W + 1;                      // difference width
    localparam int VM_W   = W + 1;                      // velocity magnitude
    localparam int DM_W   = tpsd_pkg::DM_W;
    localparam int SQ_W   = tpsd_pkg::SQ_W;
    localparam int RT_W   = tpsd_pkg::RT_W;
    localparam int VA_W   = tpsd_pkg::VA_W;
    localparam int REM_W  = RT_W + 2;
    localparam int PV_W   = DM_W + VM_W;
    localparam int SH_W   = $clog2(W);
    localparam int SH_MAX = (W > 31) ? W - 31 : 0;
    localparam int CMP_W  = (DW > 33) ? DW : 33;
    localparam int LEN_W  = (W + 1 > RT_W) ? W + 1 : RT_W;
    localparam int SPP_W  = LEN_W + W - 1;
    localparam int SP_W   = SPP_W - FRAC_BITS;
    localparam int VS_W   = VM_W + 3;
    localparam int CL_W   = (VS_W > VA_W) ? VS_W : VA_W;
    localparam int DPP_W  = VA_W + W - 1;
    localparam int DP_W   = DPP_W - FRAC_BITS;
    localparam int TOT_W  = ((SP_W > DP_W) ? SP_W : DP_W) + 2;
    localparam int FP_W   = W + DM_W;

    localparam logic [CMP_W-1:0] SCALE_LIMIT = CMP_W'(1) << 31;
    localparam logic [CL_W-1:0]  VA_CLAMP    = CL_W'({VA_W{1'b1}});
    localparam logic signed [TOT_W-1:0] T_MAX =
        {{(TOT_W-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [TOT_W-1:0] T_MIN = ~T_MAX;

    // sideband through the square root
    typedef struct packed {
        logic [2:0][PV_W-1:0] pv;
        logic [2:0][DM_W-1:0] dm;
        logic [2:0]           dneg;
        logic [2:0]           vneg;
        logic [SH_W-1:0]      s;
        logic                 zero;
    } rt_side_t;

    // sideband through the velocity divider and the damper stages
    typedef struct packed {
        logic [2:0][DM_W-1:0] dm;
        logic [2:0]           dneg;
        logic [2:0]           vneg;
        logic                 zero;
        logic [RT_W-1:0]      lp;
        logic [SP_W-1:0]      spm;
        logic                 spneg;
    } mv_side_t;

    // sideband through the force divider
    typedef struct packed {
        logic [2:0] dneg;
        logic       tneg;
        logic       zero;
    } fk_side_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [W-2:0] stiff_reg;
    logic [W-2:0] damp_reg;
    logic [W-2:0] flen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiff_reg <= '0;
            damp_reg  <= '0;
            flen_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tpsd_pkg::REG_STIFFNESS:   stiff_reg <= cfg_data;
                tpsd_pkg::REG_DAMPING:     damp_reg  <= cfg_data;
                tpsd_pkg::REG_FREE_LENGTH: flen_reg  <= cfg_data;
                default:                   ;   // unmapped index, dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // flow control
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic out_en;
    logic en;
    logic fk_valid_last;

    assign out_en       = !out_valid_reg || result.ready;
    // a bubble in front of the result register lets the rest move on
    assign en           = out_en || !fk_valid_last;
    assign points.ready = en;

    // ------------------------------------------------------------------
    // stage a: separation and relative velocity
    // ------------------------------------------------------------------
    logic [DW-1:0] a_d_next [3];
    logic [DW-1:0] a_v_next [3];
    logic [DW-1:0] a_d_reg  [3];
    logic [DW-1:0] a_v_reg  [3];
    logic          a_valid_reg;

    assign a_d_next[0] = {points.second_pos_x[W-1], points.second_pos_x}
                       - {points.first_pos_x[W-1], points.first_pos_x};
    assign a_d_next[1] = {points.second_pos_y[W-1], points.second_pos_y}
                       - {points.first_pos_y[W-1], points.first_pos_y};
    assign a_d_next[2] = {points.second_pos_z[W-1], points.second_pos_z}
                       - {points.first_pos_z[W-1], points.first_pos_z};
    assign a_v_next[0] = {points.second_vel_x[W-1], points.second_vel_x}
                       - {points.first_vel_x[W-1], points.first_vel_x};
    assign a_v_next[1] = {points.second_vel_y[W-1], points.second_vel_y}
                       - {points.first_vel_y[W-1], points.first_vel_y};
    assign a_v_next[2] = {points.second_vel_z[W-1], points.second_vel_z}
                       - {points.first_vel_z[W-1], points.first_vel_z};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_d_reg <= a_d_next;
            a_v_reg <= a_v_next;
        end
    end

    // ------------------------------------------------------------------
    // stage b: magnitudes and range scaling into 32 bits
    // ------------------------------------------------------------------
    logic [DW-1:0]   dmag [3];
    logic [DW-1:0]   maxm;
    logic [DM_W-1:0] b_dm_next [3];
    logic [VM_W-1:0] b_vm_next [3];
    logic [2:0]      b_dneg_next;
    logic [2:0]      b_vneg_next;
    logic [SH_W-1:0] b_s_next;
    logic            b_zero_next;

    logic [DM_W-1:0] b_dm_reg [3];
    logic [VM_W-1:0] b_vm_reg [3];
    logic [2:0]      b_dneg_reg;
    logic [2:0]      b_vneg_reg;
    logic [SH_W-1:0] b_s_reg;
    logic            b_zero_reg;
    logic            b_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            b_dneg_next[i] = a_d_reg[i][DW-1];
            dmag[i]        = b_dneg_next[i] ? (~a_d_reg[i] + 1'b1) : a_d_reg[i];
            b_vneg_next[i] = a_v_reg[i][DW-1];
            b_vm_next[i]   = b_vneg_next[i] ? (~a_v_reg[i] + 1'b1) : a_v_reg[i];
        end
        maxm = dmag[0];
        if (dmag[1] > maxm)
        begin
            maxm = dmag[1];
        end
        if (dmag[2] > maxm)
        begin
            maxm = dmag[2];
        end
        b_zero_next = (maxm == '0);
        // smallest shift that brings the largest axis to 2^31 or below
        b_s_next = '0;
        for (int k = SH_MAX; k >= 0; k--)
        begin
            if ((CMP_W'(maxm) >> k) <= SCALE_LIMIT)
            begin
                b_s_next = SH_W'(k);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            b_dm_next[i] = DM_W'(CMP_W'(dmag[i]) >> b_s_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_dm_reg   <= b_dm_next;
            b_vm_reg   <= b_vm_next;
            b_dneg_reg <= b_dneg_next;
            b_vneg_reg <= b_vneg_next;
            b_s_reg    <= b_s_next;
            b_zero_reg <= b_zero_next;
        end
    end

    // ------------------------------------------------------------------
    // stage c: squares and separation-velocity products
    // ------------------------------------------------------------------
    logic [SQ_W-1:0] c_sq_reg [3];
    rt_side_t        c_side_next;
    rt_side_t        c_side_reg;
    logic            c_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_side_next.pv[i]   = PV_W'(b_dm_reg[i]) * PV_W'(b_vm_reg[i]);
            c_side_next.dm[i]   = b_dm_reg[i];
        end
        c_side_next.dneg = b_dneg_reg;
        c_side_next.vneg = b_vneg_reg;
        c_side_next.s    = b_s_reg;
        c_side_next.zero = b_zero_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                c_sq_reg[i] <= SQ_W'(b_dm_reg[i]) * SQ_W'(b_dm_reg[i]);
            end
            c_side_reg <= c_side_next;
        end
    end

    // ------------------------------------------------------------------
    // stage d: sum of squares (below 2^64 after scaling)
    // ------------------------------------------------------------------
    logic [SQ_W-1:0] d_sum_reg;
    rt_side_t        d_side_reg;
    logic            d_valid_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_sum_reg  <= c_sq_reg[0] + c_sq_reg[1] + c_sq_reg[2];
            d_side_reg <= c_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // square root: one root bit per stage, floor result
    // ------------------------------------------------------------------
    logic [REM_W-1:0] sq_rem_reg  [RT_W];
    logic [RT_W-1:0]  sq_root_reg [RT_W];
    logic [SQ_W-1:0]  sq_rad_reg  [RT_W];
    rt_side_t         sq_side_reg [RT_W];
    logic [RT_W-1:0]  sq_valid_reg;

    for (genvar k = 0; k < RT_W; k++)
    begin : g_sqrt
        logic [REM_W-1:0] rem_prev;
        logic [RT_W-1:0]  root_prev;
        logic [SQ_W-1:0]  rad_prev;
        rt_side_t         side_prev;
        logic [REM_W-1:0] rem2;
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] rem_next;
        logic [RT_W-1:0]  root_next;

        if (k == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = d_sum_reg;
            assign side_prev = d_side_reg;
        end
        else
        begin : g_rest
            assign rem_prev  = sq_rem_reg[k-1];
            assign root_prev = sq_root_reg[k-1];
            assign rad_prev  = sq_rad_reg[k-1];
            assign side_prev = sq_side_reg[k-1];
        end

        assign rem2      = {rem_prev[RT_W-1:0], rad_prev[SQ_W-1 -: 2]};
        assign trial     = {root_prev, 2'b01};
        assign rem_next  = (rem2 >= trial) ? (rem2 - trial) : rem2;
        assign root_next = {root_prev[RT_W-2:0], (rem2 >= trial)};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rem_reg[k]  <= rem_next;
                sq_root_reg[k] <= root_next;
                sq_rad_reg[k]  <= rad_prev << 2;
                sq_side_reg[k] <= side_prev;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage e: length and extension
    // ------------------------------------------------------------------
    rt_side_t        sq_out;
    logic [LEN_W-1:0] e_len;
    logic [LEN_W:0]   e_ext;
    logic [LEN_W:0]   e_ext_abs;

    logic [LEN_W-1:0] e_extm_reg;
    logic             e_extneg_reg;
    logic [RT_W-1:0]  e_lp_reg;
    rt_side_t         e_side_reg;
    logic             e_valid_reg;

    assign sq_out    = sq_side_reg[RT_W-1];
    assign e_len     = LEN_W'(sq_root_reg[RT_W-1]) << sq_out.s;
    assign e_ext     = {1'b0, e_len} - (LEN_W+1)'(flen_reg);
    assign e_ext_abs = e_ext[LEN_W] ? (~e_ext + 1'b1) : e_ext;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_extm_reg   <= e_ext_abs[LEN_W-1:0];
            e_extneg_reg <= e_ext[LEN_W];
            e_lp_reg     <= sq_root_reg[RT_W-1];
            e_side_reg   <= sq_out;
        end
    end

    // ------------------------------------------------------------------
    // stage f: spring force magnitude
    // ------------------------------------------------------------------
    logic [SPP_W-1:0] f_spp;
    mv_side_t         f_side_next;
    mv_side_t         f_side_reg;
    logic [2:0][PV_W-1:0] f_pv_reg;
    logic             f_valid_reg;

    assign f_spp = SPP_W'(e_extm_reg) * SPP_W'(stiff_reg);

    always_comb
    begin
        f_side_next.dm    = e_side_reg.dm;
        f_side_next.dneg  = e_side_reg.dneg;
        f_side_next.vneg  = e_side_reg.vneg;
        f_side_next.zero  = e_side_reg.zero;
        f_side_next.lp    = e_lp_reg;
        f_side_next.spm   = f_spp[SPP_W-1:FRAC_BITS];
        f_side_next.spneg = e_extneg_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_side_reg <= f_side_next;
            f_pv_reg   <= e_side_reg.pv;
        end
    end

    // ------------------------------------------------------------------
    // axial velocity terms: dm*|v| / root, one divider per axis
    // ------------------------------------------------------------------
    logic [VM_W-1:0] mv_quo [3];
    mv_side_t        mv_side_reg [VM_W];
    logic [VM_W-1:0] mv_valid_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_vdiv
        tpsd_div_pipe #(
            .DEN_W (RT_W),
            .QUO_W (VM_W)
        ) u_div (
            .clk (clk),
            .en  (en),
            .num (f_pv_reg[i]),
            .den (f_side_reg.lp),
            .quo (mv_quo[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mv_side_reg[0] <= f_side_reg;
            for (int k = 1; k < VM_W; k++)
            begin
                mv_side_reg[k] <= mv_side_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage g: signed axial velocity
    // ------------------------------------------------------------------
    mv_side_t                mv_out;
    logic signed [VS_W-1:0]  g_term [3];
    logic signed [VS_W-1:0]  g_va_reg;
    mv_side_t                g_side_reg;
    logic                    g_valid_reg;

    assign mv_out = mv_side_reg[VM_W-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            g_term[i] = (mv_out.dneg[i] ^ mv_out.vneg[i])
                      ? -VS_W'(mv_quo[i]) : VS_W'(mv_quo[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_va_reg   <= g_term[0] + g_term[1] + g_term[2];
            g_side_reg <= mv_out;
        end
    end

    // ------------------------------------------------------------------
    // stage h: clamp and damper force magnitude
    // ------------------------------------------------------------------
    logic [VS_W-1:0]  h_vam;
    logic [CL_W-1:0]  h_vam_ext;
    logic [CL_W-1:0]  h_vam_clamp;
    logic [DPP_W-1:0] h_dpp;

    logic [DP_W-1:0]  h_dpm_reg;
    logic             h_dpneg_reg;
    mv_side_t         h_side_reg;
    logic             h_valid_reg;

    assign h_vam       = g_va_reg[VS_W-1] ? -g_va_reg : g_va_reg;
    assign h_vam_ext   = CL_W'(h_vam);
    assign h_vam_clamp = (h_vam_ext > VA_CLAMP) ? VA_CLAMP : h_vam_ext;
    assign h_dpp       = DPP_W'(h_vam_clamp[VA_W-1:0]) * DPP_W'(damp_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_dpm_reg   <= h_dpp[DPP_W-1:FRAC_BITS];
            h_dpneg_reg <= g_va_reg[VS_W-1];
            h_side_reg  <= g_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage i: total tension, saturated
    // ------------------------------------------------------------------
    logic signed [TOT_W-1:0] i_sp;
    logic signed [TOT_W-1:0] i_dp;
    logic signed [TOT_W-1:0] i_tot;
    logic [W-1:0]            i_tsat;

    logic [W-1:0]            i_tm_reg;
    logic                    i_tneg_reg;
    mv_side_t                i_side_reg;
    logic                    i_valid_reg;

    assign i_sp  = h_side_reg.spneg ? -TOT_W'(h_side_reg.spm) : TOT_W'(h_side_reg.spm);
    assign i_dp  = h_dpneg_reg ? -TOT_W'(h_dpm_reg) : TOT_W'(h_dpm_reg);
    assign i_tot = i_sp + i_dp;

    always_comb
    begin
        if (i_tot > T_MAX)
        begin
            i_tsat = T_MAX[W-1:0];
        end
        else if (i_tot < T_MIN)
        begin
            i_tsat = T_MIN[W-1:0];
        end
        else
        begin
            i_tsat = i_tot[W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_tm_reg   <= i_tsat[W-1] ? (~i_tsat + 1'b1) : i_tsat;
            i_tneg_reg <= i_tot[TOT_W-1];
            i_side_reg <= h_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage j: tension times scaled separation
    // ------------------------------------------------------------------
    logic [2:0][FP_W-1:0] j_fp_reg;
    logic [RT_W-1:0]      j_lp_reg;
    fk_side_t             j_side_reg;
    logic                 j_valid_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                j_fp_reg[i] <= FP_W'(i_tm_reg) * FP_W'(i_side_reg.dm[i]);
            end
            j_lp_reg        <= i_side_reg.lp;
            j_side_reg.dneg <= i_side_reg.dneg;
            j_side_reg.tneg <= i_tneg_reg;
            j_side_reg.zero <= i_side_reg.zero;
        end
    end

    // ------------------------------------------------------------------
    // force components: tension*dm / root, one divider per axis
    // ------------------------------------------------------------------
    logic [W-1:0]  fk_quo [3];
    fk_side_t      fk_side_reg [W];
    logic [W-1:0]  fk_valid_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_fdiv
        tpsd_div_pipe #(
            .DEN_W (RT_W),
            .QUO_W (W)
        ) u_div (
            .clk (clk),
            .en  (en),
            .num (j_fp_reg[i]),
            .den (j_lp_reg),
            .quo (fk_quo[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fk_side_reg[0] <= j_side_reg;
            for (int k = 1; k < W; k++)
            begin
                fk_side_reg[k] <= fk_side_reg[k-1];
            end
        end
    end

    assign fk_valid_last = fk_valid_reg[W-1];

    // ------------------------------------------------------------------
    // result register: sign, saturation, coincident points
    // ------------------------------------------------------------------
    fk_side_t     fk_out;
    logic [W-1:0] force_next [3];
    logic [W-1:0] force_reg  [3];
    logic         zero_reg;

    assign fk_out = fk_side_reg[W-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (fk_out.zero)
            begin
                force_next[i] = '0;
            end
            else if (fk_out.tneg ^ fk_out.dneg[i])
            begin
                force_next[i] = ~fk_quo[i] + 1'b1;
            end
            else if (fk_quo[i][W-1])
            begin
                // magnitude of exactly 2^(W-1) only reachable from below
                force_next[i] = {1'b0, {(W-1){1'b1}}};
            end
            else
            begin
                force_next[i] = fk_quo[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            force_reg <= force_next;
            zero_reg  <= fk_out.zero;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.force_x     = force_reg[0];
    assign result.force_y     = force_reg[1];
    assign result.force_z     = force_reg[2];
    assign result.zero_length = zero_reg;

    // ------------------------------------------------------------------
    // stage valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            sq_valid_reg  <= '0;
            e_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            mv_valid_reg  <= '0;
            g_valid_reg   <= 1'b0;
            h_valid_reg   <= 1'b0;
            i_valid_reg   <= 1'b0;
            j_valid_reg   <= 1'b0;
            fk_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                a_valid_reg  <= points.valid;
                b_valid_reg  <= a_valid_reg;
                c_valid_reg  <= b_valid_reg;
                d_valid_reg  <= c_valid_reg;
                sq_valid_reg <= {sq_valid_reg[RT_W-2:0], d_valid_reg};
                e_valid_reg  <= sq_valid_reg[RT_W-1];
                f_valid_reg  <= e_valid_reg;
                mv_valid_reg <= {mv_valid_reg[VM_W-2:0], f_valid_reg};
                g_valid_reg  <= mv_valid_reg[VM_W-1];
                h_valid_reg  <= g_valid_reg;
                i_valid_reg  <= h_valid_reg;
                j_valid_reg  <= i_valid_reg;
                fk_valid_reg <= {fk_valid_reg[W-2:0], j_valid_reg};
            end
            if (out_en)
            begin
                out_valid_reg <= fk_valid_last;
            end
        end
    end

endmodule

`default_nettype wire

### tb/tb_two_point_spring_damper_force_top.sv
`default_nettype none

module tb_two_point_spring_damper_force_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = 32;
    localparam int FB = 16;
    // latency of the pipe, plus some margin for the drain at the end
    localparam int PIPE_LAT = 2 * DW + 44;
    localparam int DRAIN_CYCLES = PIPE_LAT + 50;
    localparam int N_RANDOM = 1250;
    localparam int LONG_HOLD = 400;
    // an index past the last register, which the block must ignore
    localparam logic [tpsd_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
    localparam logic signed [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-2:0] R_MAX = {(DW-1){1'b1}};
    localparam logic [DW-2:0] ONE_Q = 31'h0001_0000;

    typedef struct {
        logic signed [DW-1:0] p1[3];
        logic signed [DW-1:0] p2[3];
        logic signed [DW-1:0] v1[3];
        logic signed [DW-1:0] v2[3];
    } points_t;

    typedef struct {
        logic signed [DW-1:0] f[3];
        logic                 zero;
    } force_t;

    // predicts the force for each accepted transfer and checks the results in order
    class force_scoreboard;
        longint unsigned k_spring;
        longint unsigned k_damp;
        longint unsigned len_free;
        force_t          forces_due[$];
        int              n_err;
        int              n_checked;
        int              n_coincident;

        function new();
            k_spring = 0;
            k_damp = 0;
            len_free = 0;
            n_err = 0;
            n_checked = 0;
            n_coincident = 0;
        endfunction

        function void set_reg(logic [tpsd_pkg::CFG_IDX_W-1:0] idx, logic [DW-2:0] val);
            case (idx)
                tpsd_pkg::REG_STIFFNESS:   k_spring = longint'(val);
                tpsd_pkg::REG_DAMPING:     k_damp = longint'(val);
                tpsd_pkg::REG_FREE_LENGTH: len_free = longint'(val);
                default: ;
            endcase
        endfunction

        function longint unsigned magn(longint x);
            return x < 0 ? longint'(0) - x : x;
        endfunction

        function longint clip(longint x);
            if (x > longint'(S_MAX))
                return longint'(S_MAX);
            if (x < longint'(S_MIN))
                return longint'(S_MIN);
            return x;
        endfunction

        // bit-pair integer square root, floor
        function longint unsigned root_floor(longint unsigned s);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > s)
                b = b >> 2;
            while (b != 0)
            begin
                if (s >= r + b)
                begin
                    s = s - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function force_t spring_damper_force(points_t p);
            longint          d[3];
            longint          v[3];
            bit              dneg[3];
            longint unsigned dm[3];
            longint unsigned maxm, sum, lp, len, spm, vam, tm, t, fm;
            longint          ext, sp, va, dp, tot;
            int              s;
            force_t          r;
            maxm = 0;
            for (int i = 0; i < 3; i++)
            begin
                d[i] = longint'(p.p2[i]) - longint'(p.p1[i]);
                v[i] = longint'(p.v2[i]) - longint'(p.v1[i]);
                dm[i] = magn(d[i]);
                if (dm[i] > maxm)
                    maxm = dm[i];
            end
            if (maxm == 0)
            begin
                for (int i = 0; i < 3; i++)
                    r.f[i] = '0;
                r.zero = 1'b1;
                return r;
            end
            // shift the separation down so its square sum fits 64 bits
            s = 0;
            while (s < 63 && (maxm >> s) > 64'h8000_0000)
                s++;
            sum = 0;
            for (int i = 0; i < 3; i++)
            begin
                dm[i] = dm[i] >> s;
                dneg[i] = d[i] < 0 && dm[i] != 0;
                sum = sum + dm[i] * dm[i];
            end
            lp = root_floor(sum);
            if (lp == 0)
                lp = 1;
            len = lp << s;
            // spring term, product wraps at 64 bits
            ext = longint'(len) - longint'(len_free);
            spm = (magn(ext) * k_spring) >> FB;
            sp = ext < 0 ? longint'(0) - longint'(spm) : longint'(spm);
            // relative velocity along the unit direction
            va = 0;
            for (int i = 0; i < 3; i++)
            begin
                t = (dm[i] * magn(v[i])) / lp;
                va = va + ((dneg[i] != (v[i] < 0)) ? longint'(0) - longint'(t) : longint'(t));
            end
            vam = magn(va);
            if (vam > 64'h1_FFFF_FFFF)
                vam = 64'h1_FFFF_FFFF;
            t = (vam * k_damp) >> FB;
            dp = va < 0 ? longint'(0) - longint'(t) : longint'(t);
            tot = clip(sp + dp);
            tm = magn(tot);
            for (int i = 0; i < 3; i++)
            begin
                fm = (tm * dm[i]) / lp;
                r.f[i] = DW'(clip(((tot < 0) != dneg[i]) ? longint'(0) - longint'(fm)
                                                         : longint'(fm)));
            end
            r.zero = 1'b0;
            return r;
        endfunction

        function void note_points(points_t p);
            forces_due.push_back(spring_damper_force(p));
        endfunction

        function void check_force(force_t got);
            force_t want;
            bit     bad;
            if (forces_due.size() == 0)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("error: result with nothing pending: f=%0d %0d %0d z=%0b",
                             got.f[0], got.f[1], got.f[2], got.zero);
                return;
            end
            want = forces_due.pop_front();
            n_checked++;
            if (want.zero)
                n_coincident++;
            bad = got.zero !== want.zero;
            for (int i = 0; i < 3; i++)
                if (got.f[i] !== want.f[i])
                    bad = 1;
            if (bad)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("error: result %0d expected f=%0d %0d %0d z=%0b got f=%0d %0d %0d z=%0b",
                             n_checked, want.f[0], want.f[1], want.f[2], want.zero,
                             got.f[0], got.f[1], got.f[2], got.zero);
            end
        endfunction

        function int pending();
            return forces_due.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [tpsd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [DW-2:0] cfg_data;

    tpsd_in_if  #(.DATA_WIDTH(DW)) points_if ();
    tpsd_out_if #(.DATA_WIDTH(DW)) result_if ();

    two_point_spring_damper_force_top #(
        .DATA_WIDTH(DW),
        .FRAC_BITS (FB)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .points   (points_if),
        .result   (result_if)
    );

    force_scoreboard sb;

    // knobs shared between the sender and the receiver
    bit no_idle;
    bit hold_req;
    int n_sent;
    int n_cfg;

    initial
        sb = new();

    // 2 ns clock
    initial
        clk = 1'b0;
    always #1 clk = ~clk;

    // hard limit on the run, well past the slowest legal run
    initial
    begin
        #2_000_000;
        $display("timeout with %0d results pending", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

    // gap length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // input monitor: every accepted transfer goes to the predictor
    always @(posedge clk)
    begin
        if (rst_n && points_if.valid && points_if.ready)
        begin
            points_t p;
            p.p1[0] = points_if.first_pos_x;
            p.p1[1] = points_if.first_pos_y;
            p.p1[2] = points_if.first_pos_z;
            p.p2[0] = points_if.second_pos_x;
            p.p2[1] = points_if.second_pos_y;
            p.p2[2] = points_if.second_pos_z;
            p.v1[0] = points_if.first_vel_x;
            p.v1[1] = points_if.first_vel_y;
            p.v1[2] = points_if.first_vel_z;
            p.v2[0] = points_if.second_vel_x;
            p.v2[1] = points_if.second_vel_y;
            p.v2[2] = points_if.second_vel_z;
            sb.note_points(p);
        end
    end

    // output monitor: every result transfer is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            force_t g;
            g.f[0] = result_if.force_x;
            g.f[1] = result_if.force_y;
            g.f[2] = result_if.force_z;
            g.zero = result_if.zero_length;
            sb.check_force(g);
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request so the
    // pipe fills up and the input side has to stall
    initial
    begin
        int hold_cnt;
        int g;
        hold_cnt = 0;
        result_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (hold_cnt > 0)
            begin
                result_if.ready <= 1'b0;
                hold_cnt--;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cnt = LONG_HOLD;
                result_if.ready <= 1'b0;
            end
            else
            begin
                g = idle_len();
                if (g > 0)
                begin
                    result_if.ready <= 1'b0;
                    hold_cnt = g - 1;
                end
                else
                    result_if.ready <= 1'b1;
            end
        end
    end

    // drive one item and hold it until the block takes it
    task automatic send_points(points_t p);
        int g;
        points_if.valid <= 1'b1;
        points_if.first_pos_x <= p.p1[0];
        points_if.first_pos_y <= p.p1[1];
        points_if.first_pos_z <= p.p1[2];
        points_if.second_pos_x <= p.p2[0];
        points_if.second_pos_y <= p.p2[1];
        points_if.second_pos_z <= p.p2[2];
        points_if.first_vel_x <= p.v1[0];
        points_if.first_vel_y <= p.v1[1];
        points_if.first_vel_z <= p.v1[2];
        points_if.second_vel_x <= p.v2[0];
        points_if.second_vel_y <= p.v2[1];
        points_if.second_vel_z <= p.v2[2];
        @(posedge clk);
        while (!points_if.ready)
            @(posedge clk);
        n_sent++;
        // valid only drops when a gap follows, so it never toggles within one step
        g = idle_len();
        if (g > 0)
        begin
            points_if.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // drop valid and wait until every predicted result is out
    task automatic drain_results();
        points_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // the write enable stays up across back-to-back writes; the caller drops it
    task automatic write_reg(logic [tpsd_pkg::CFG_IDX_W-1:0] idx, logic [DW-2:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        n_cfg++;
    endtask

    // registers only change with the pipe empty; results are one per item, so an
    // empty queue plus a pipe's worth of cycles means nothing is in flight
    task automatic set_params(logic [DW-2:0] k, logic [DW-2:0] c, logic [DW-2:0] l0);
        drain_results();
        repeat (PIPE_LAT) @(posedge clk);
        write_reg(tpsd_pkg::REG_STIFFNESS, k);
        write_reg(tpsd_pkg::REG_DAMPING, c);
        write_reg(tpsd_pkg::REG_FREE_LENGTH, l0);
        // a write past the last register must leave all three alone
        write_reg(CFG_IDX_UNUSED, 31'($urandom));
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [DW-1:0] corner_val();
        case ($urandom_range(0, 5))
            0: return S_MAX;
            1: return S_MIN;
            2: return '0;
            3: return '1;
            4: return 32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // mix of coincident points, near points, corner values and full-range values
    function automatic points_t random_points();
        points_t p;
        int      kind;
        int      span;
        kind = $urandom_range(0, 9);
        span = $urandom_range(4, 24);
        for (int i = 0; i < 3; i++)
        begin
            p.p1[i] = $urandom;
            case (kind)
                0: p.p2[i] = p.p1[i];
                1, 2, 3, 4: p.p2[i] = p.p1[i] + ($signed($urandom) >>> (31 - span));
                5:
                begin
                    p.p1[i] = corner_val();
                    p.p2[i] = corner_val();
                end
                default: p.p2[i] = $urandom;
            endcase
            if ($urandom_range(0, 2) == 0)
            begin
                p.v1[i] = $urandom;
                p.v2[i] = $urandom;
            end
            else
            begin
                p.v1[i] = $signed($urandom) >>> $urandom_range(4, 20);
                p.v2[i] = $signed($urandom) >>> $urandom_range(4, 20);
            end
        end
        return p;
    endfunction

    function automatic points_t axis_points(int ax, logic signed [DW-1:0] sep,
                                            logic signed [DW-1:0] rel_vel);
        points_t p;
        for (int i = 0; i < 3; i++)
        begin
            p.p1[i] = 32'sh0001_0000;
            p.p2[i] = 32'sh0001_0000;
            p.v1[i] = '0;
            p.v2[i] = '0;
        end
        p.p2[ax] = p.p1[ax] + sep;
        p.v2[ax] = rel_vel;
        return p;
    endfunction

    task automatic run_directed();
        points_t p;
        // coincident points, with and without relative motion
        p = axis_points(0, '0, '0);
        send_points(p);
        p = axis_points(1, '0, S_MAX);
        send_points(p);
        // long and short separations on every axis, both directions, stretch and squeeze
        for (int ax = 0; ax < 3; ax++)
        begin
            p = axis_points(ax, 32'sh0003_0000, 32'sh0000_8000);
            send_points(p);
            p = axis_points(ax, -32'sh0000_8000, -32'sh0002_0000);
            send_points(p);
        end
        // one lsb apart
        p = axis_points(2, 32'sd1, '0);
        send_points(p);
        // separation spanning the whole range on each axis, needs range scaling
        for (int i = 0; i < 3; i++)
        begin
            p.p1[i] = S_MIN;
            p.p2[i] = S_MAX;
            p.v1[i] = S_MIN;
            p.v2[i] = S_MAX;
        end
        send_points(p);
        for (int i = 0; i < 3; i++)
        begin
            p.p1[i] = S_MAX;
            p.p2[i] = S_MIN;
            p.v1[i] = S_MAX;
            p.v2[i] = S_MIN;
        end
        send_points(p);
        // mixed extremes across axes
        for (int i = 0; i < 3; i++)
        begin
            p.p1[i] = (i == 1) ? S_MIN : '0;
            p.p2[i] = (i == 1) ? '0 : S_MAX;
            p.v1[i] = '1;
            p.v2[i] = (i == 0) ? S_MIN : 32'sd1;
        end
        send_points(p);
        // all-ones fields
        for (int i = 0; i < 3; i++)
        begin
            p.p1[i] = '0;
            p.p2[i] = '1;
            p.v1[i] = '1;
            p.v2[i] = '0;
        end
        send_points(p);
        // diagonal separation with velocity across the spring
        for (int i = 0; i < 3; i++)
        begin
            p.p1[i] = -32'sh0001_0000;
            p.p2[i] = 32'sh0001_0000;
            p.v1[i] = (i == 0) ? 32'sh0004_0000 : '0;
            p.v2[i] = (i == 2) ? 32'sh0004_0000 : '0;
        end
        send_points(p);
    endtask

    task automatic run_random(int n);
        for (int k = 0; k < n; k++)
            send_points(random_points());
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= tpsd_pkg::REG_STIFFNESS;
        cfg_data <= '0;
        points_if.valid <= 1'b0;
        points_if.first_pos_x <= '0;
        points_if.first_pos_y <= '0;
        points_if.first_pos_z <= '0;
        points_if.second_pos_x <= '0;
        points_if.second_pos_y <= '0;
        points_if.second_pos_z <= '0;
        points_if.first_vel_x <= '0;
        points_if.first_vel_y <= '0;
        points_if.first_vel_z <= '0;
        points_if.second_vel_x <= '0;
        points_if.second_vel_y <= '0;
        points_if.second_vel_z <= '0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        n_sent = 0;
        n_cfg = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a few items with the reset register values
        run_directed();

        // typical spring: stiffness 1.0, damping 0.25, free length 2.0
        set_params(ONE_Q, 31'h0000_4000, 31'h0002_0000);
        run_directed();
        run_random(150);

        // long receiver hold-off while the sender keeps going, so the pipe backs up
        hold_req = 1'b1;
        run_random(200);

        // sender stops until the pipe is empty, then carries on in the same setting
        drain_results();
        run_random(50);

        // every register at its top value
        set_params(R_MAX, R_MAX, R_MAX);
        run_random(150);

        // all zero
        set_params('0, '0, '0);
        run_random(100);

        // no idling anywhere for a stretch
        set_params(31'h0000_8000, 31'h0001_0000, '0);
        no_idle = 1'b1;
        run_random(150);
        no_idle = 1'b0;

        // several random settings, heavy on small values
        for (int ph = 0; ph < 5; ph++)
        begin
            set_params(31'($urandom) >> $urandom_range(0, 24),
                       31'($urandom) >> $urandom_range(0, 24),
                       31'($urandom) >> $urandom_range(0, 16));
            run_random(90);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d point pairs over %0d register writes, checked %0d forces",
                 n_sent, n_cfg, sb.n_checked);
        $display("%0d coincident-point results, %0d mismatches",
                 sb.n_coincident, sb.n_err);
        if (sb.n_err == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
src/tpsd_pkg.sv
src/tpsd_in_if.sv
src/tpsd_out_if.sv
src/tpsd_div_pipe.sv
src/two_point_spring_damper_force_top.sv
tb/tb_two_point_spring_damper_force_top.sv
